// File: rtl/core/bpr_pkg.sv
// Shared types, constants and helpers for the band pixel reorder block.
// Used by bpr_front, bpr_queue, bpr_back and band_pixel_reorder.
`default_nettype none

package bpr_pkg;

	// Frame geometry
	localparam int ROW_BYTES  = 32;
	localparam int BANDS      = 16;
	localparam int BAND_ROWS  = 12;
	localparam int STORE_ROWS = BAND_ROWS - 1;
	localparam int COL_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int ROW_W      = $clog2(BAND_ROWS);

	// Unpacker step counts
	localparam logic [1:0] LAST_LINE  = 2'd3;
	localparam logic [1:0] LAST_GROUP = 2'd2;
	localparam logic [1:0] GROUP_LO   = 2'd0;
	localparam logic [1:0] GROUP_MID  = 2'd1;

	// One column of a band: twelve row bytes and the end-of-frame mark
	typedef struct packed {
		logic [BAND_ROWS-1:0][7:0] rows;
		logic                      frame_end;
	} job_t;

	// Pick the 2-bit pixel pair at bits (7-2*line, 6-2*line)
	function automatic logic [1:0] pair_at(input logic [7:0] b, input logic [1:0] line);
		logic [1:0] p;
		case (line)
			2'd0:    p = b[7:6];
			2'd1:    p = b[5:4];
			2'd2:    p = b[3:2];
			default: p = b[1:0];
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/bpr_front.sv
// Front end: frame counters, band store, and column job assembly.
// Depends on bpr_pkg; feeds bpr_queue.
`default_nettype none

module bpr_front
	import bpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] pixel_byte,
	output logic            job_push,
	output job_t            job,
	input  wire logic       q_full
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [BAND_W-1:0] band_q;
	logic              valid_s1;
	logic [STORE_ROWS-1:0][7:0] rd_s1;
	logic [7:0]        byte_s1;
	logic              frame_end_s1;
	logic [STORE_ROWS-1:0][7:0] store_q [ROW_BYTES];

	logic accept;
	logic last_row;
	logic last_col;
	logic last_band;

	assign full      = valid_s1 && q_full;
	assign accept    = push && !full;
	assign last_row  = (row_q == ROW_W'(BAND_ROWS - 1));
	assign last_col  = (col_q == COL_W'(ROW_BYTES - 1));
	assign last_band = (band_q == BAND_W'(BANDS - 1));

	// Advance column, row and band counters on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			band_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					band_q <= last_band ? '0 : band_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Store rows 0..10; read the whole column when row 11 arrives
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!last_row) begin
				store_q[col_q][row_q] <= pixel_byte;
			end else begin
				rd_s1        <= store_q[col_q];
				byte_s1      <= pixel_byte;
				frame_end_s1 <= last_col && last_band;
			end
		end
	end

	// Hold the job until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= last_row;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	assign job_push      = valid_s1 && !q_full;
	assign job.rows      = {byte_s1, rd_s1};
	assign job.frame_end = frame_end_s1;

endmodule

`default_nettype wire

// File: rtl/core/bpr_queue.sv
// Two-entry job queue between the front end and the unpacker.
// Depends on bpr_pkg for job_t.
`default_nettype none

module bpr_queue
	import bpr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_push,
	input  job_t      in_job,
	output logic      q_full,
	output logic      q_valid,
	output job_t      out_job,
	input  wire logic out_pop
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign out_job = slot_q[rd_ptr_q];

	// Write the incoming job
	always_ff @(posedge clk) begin
		if (in_push) begin
			slot_q[wr_ptr_q] <= in_job;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (in_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({in_push, out_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bpr_back.sv
// Unpacker: turns one column job into twelve panel bytes, one per cycle while popped.
// Depends on bpr_pkg; takes jobs from bpr_queue.
`default_nettype none

module bpr_back
	import bpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  job_t            q_job,
	output logic            q_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      panel_byte,
	output logic            last_of_column,
	output logic            last_of_frame
);

	job_t       job_q;
	logic       busy_q;
	logic [1:0] line_q;
	logic [1:0] grp_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       loc_q;
	logic       lof_q;

	logic       advance;
	logic       last_step;
	logic [7:0] packed_byte;
	logic [3:0][7:0] quad;

	assign advance   = busy_q && (!out_valid_q || pop);
	assign last_step = (line_q == LAST_LINE) && (grp_q == LAST_GROUP);
	assign q_pop     = q_valid && (!busy_q || (advance && last_step));

	// Select the four rows of the current group
	always_comb begin
		case (grp_q)
			GROUP_LO:  quad = job_q.rows[3:0];
			GROUP_MID: quad = job_q.rows[7:4];
			default:   quad = job_q.rows[11:8];
		endcase
		packed_byte = {pair_at(quad[0], line_q), pair_at(quad[1], line_q),
			pair_at(quad[2], line_q), pair_at(quad[3], line_q)};
	end

	// Load a new job and step through groups and lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			line_q <= '0;
			grp_q  <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				line_q <= '0;
				grp_q  <= '0;
			end else if (advance) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end else if (grp_q == LAST_GROUP) begin
					grp_q  <= '0;
					line_q <= line_q + 2'd1;
				end else begin
					grp_q <= grp_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	// Output register: hold until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= packed_byte;
			loc_q  <= last_step;
			lof_q  <= last_step && job_q.frame_end;
		end
	end

	assign empty          = !out_valid_q;
	assign panel_byte     = byte_q;
	assign last_of_column = loc_q;
	assign last_of_frame  = lof_q;

endmodule

`default_nettype wire

// File: rtl/core/band_pixel_reorder.sv
// Top level of the band pixel reorder block: front end, job queue, unpacker.
// Depends on bpr_pkg, bpr_front, bpr_queue and bpr_back.
//
// Takes a row-major 1-bit-per-pixel frame one byte per beat (ROW_BYTES bytes
// per row, 12 rows per band, BANDS bands per frame) and emits it in panel
// write order. Bytes of rows 0..10 go into a band store (ROW_BYTES entries
// of 11 bytes, one byte lane written per beat) and are taken one per cycle
// while full is low. The row 11 byte of a column reads that column's 11 stored
// bytes in one access and forms a job. The unpacker then emits 12 panel bytes
// for it, one per cycle while the output is popped, so during row 11 the
// input can go no faster than the unpacker takes jobs. Only about three jobs
// of one band drain while rows 0..10 of the next band come in. With no
// stalls on either side, neither side therefore averages one byte per cycle
// over a band of 384 input bytes. A two-job queue between store and unpacker
// lets input continue for a few jobs while the output is stalled. The first
// result of a column passes the front-end register, a queue slot, the job
// register and the output register. The store needs no clearing after reset.
`default_nettype none

module band_pixel_reorder
	import bpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] pixel_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      panel_byte,
	output logic            last_of_column,
	output logic            last_of_frame
);

	logic job_push;
	job_t front_job;
	logic q_full;
	logic q_valid;
	job_t q_job;
	logic q_pop;

	bpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel_byte (pixel_byte),
		.job_push   (job_push),
		.job        (front_job),
		.q_full     (q_full)
	);

	bpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (job_push),
		.in_job  (front_job),
		.q_full  (q_full),
		.q_valid (q_valid),
		.out_job (q_job),
		.out_pop (q_pop)
	);

	bpr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_job          (q_job),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.panel_byte     (panel_byte),
		.last_of_column (last_of_column),
		.last_of_frame  (last_of_frame)
	);

	// End of frame only on the last byte of a column
	a_frame_on_column: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_frame) |-> last_of_column)
		else $error("last_of_frame without last_of_column");

	// Never write a job into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("job queue overflow");

	// Never take a job from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("job queue underflow");

	// Input stalls only while a finished job waits on a full queue
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input stalled without a full queue");

endmodule

`default_nettype wire
